[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[rtl/whp_pkg.sv]
// ---------------------------------------------------------------------------
// WAV header parser package
// Parser state, phase and status codes, and the chunk id constants.
// ---------------------------------------------------------------------------
package whp_pkg;

    localparam int CountWidth = 17;

    localparam logic [2:0] PH_RIFF  = 3'd0;
    localparam logic [2:0] PH_CHUNK = 3'd1;
    localparam logic [2:0] PH_FMT   = 3'd2;
    localparam logic [2:0] PH_SKIP  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_ERR   = 3'd5;

    localparam logic [2:0] ST_PARSING   = 3'd0;
    localparam logic [2:0] ST_IN_DATA   = 3'd1;
    localparam logic [2:0] ST_NOT_WAV   = 3'd2;
    localparam logic [2:0] ST_NO_DATA   = 3'd3;
    localparam logic [2:0] ST_FMT_SHORT = 3'd4;
    localparam logic [2:0] ST_SKIP_SHORT = 3'd5;
    localparam logic [2:0] ST_NO_FMT    = 3'd6;

    localparam logic [31:0] CC_RIFF = 32'h5249_4646;
    localparam logic [31:0] CC_RF64 = 32'h5246_3634;
    localparam logic [31:0] CC_WAVE = 32'h5741_5645;
    localparam logic [31:0] CC_FMT  = 32'h666D_7420;
    localparam logic [31:0] CC_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_MIN = 32'd16;
    localparam logic [31:0] FMT_MAX = 32'd65536;

    typedef struct packed {
        logic [2:0]            phase;
        logic [CountWidth-1:0] byte_count;
        logic [31:0]           id_shift;
        logic [31:0]           size_shift;
        logic [15:0]           chan;
        logic [31:0]           rate;
        logic [15:0]           depth;
        logic                  fmt_seen;
        logic [2:0]            error_code;
    } parse_state_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] payload;
        logic       payload_valid;
    } step_result_t;

endpackage

[rtl/whp_step.sv]
// ---------------------------------------------------------------------------
// WAV header parser step
// Next parser state and result for one stream item.
// ---------------------------------------------------------------------------
module whp_step
(
    input  whp_pkg::parse_state_t cur,
    input  logic [7:0]            in_byte,
    input  logic                  end_mark,
    output whp_pkg::parse_state_t nxt,
    output whp_pkg::step_result_t res
);

    logic [31:0]                    id_new;
    logic [31:0]                    size_new;
    logic [31:0]                    size_dec;
    logic [whp_pkg::CountWidth-1:0] cnt_inc;

    assign id_new   = {cur.id_shift[23:0], in_byte};
    assign size_new = {in_byte, cur.size_shift[31:8]};
    assign size_dec = cur.size_shift - 32'd1;
    assign cnt_inc  = cur.byte_count + 1'b1;

    always_comb
    begin
        nxt               = cur;
        res.payload       = 8'd0;
        res.payload_valid = 1'b0;

        if (end_mark)
        begin
            // An end marker before the data phase is an error that depends on where we were; data ignores it.
            case (cur.phase)
                whp_pkg::PH_RIFF:
                begin
                    nxt.phase      = whp_pkg::PH_ERR;
                    nxt.error_code = whp_pkg::ST_NOT_WAV;
                end
                whp_pkg::PH_CHUNK:
                begin
                    nxt.phase      = whp_pkg::PH_ERR;
                    nxt.error_code = whp_pkg::ST_NO_DATA;
                end
                whp_pkg::PH_FMT:
                begin
                    nxt.phase      = whp_pkg::PH_ERR;
                    nxt.error_code = whp_pkg::ST_FMT_SHORT;
                end
                whp_pkg::PH_SKIP:
                begin
                    nxt.phase      = whp_pkg::PH_ERR;
                    nxt.error_code = whp_pkg::ST_SKIP_SHORT;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            case (cur.phase)
                whp_pkg::PH_RIFF:
                begin
                    nxt.id_shift = id_new;
                    if (cur.byte_count == 17'd3 && id_new != whp_pkg::CC_RIFF &&
                        id_new != whp_pkg::CC_RF64)
                    begin
                        nxt.phase      = whp_pkg::PH_ERR;
                        nxt.error_code = whp_pkg::ST_NOT_WAV;
                    end
                    else if (cur.byte_count == 17'd11)
                    begin
                        if (id_new != whp_pkg::CC_WAVE)
                        begin
                            nxt.phase      = whp_pkg::PH_ERR;
                            nxt.error_code = whp_pkg::ST_NOT_WAV;
                        end
                        else
                        begin
                            nxt.phase      = whp_pkg::PH_CHUNK;
                            nxt.byte_count = '0;
                        end
                    end
                    else
                    begin
                        nxt.byte_count = cnt_inc;
                    end
                end
                whp_pkg::PH_CHUNK:
                begin
                    if (cur.byte_count < 17'd4)
                        nxt.id_shift = id_new;
                    else
                        nxt.size_shift = size_new;
                    if (cur.byte_count != 17'd7)
                    begin
                        nxt.byte_count = cnt_inc;
                    end
                    else
                    begin
                        // Last header byte: the id is complete and the size
                        // has just been shifted in.
                        nxt.byte_count = '0;
                        if (cur.id_shift == whp_pkg::CC_FMT && size_new >= whp_pkg::FMT_MIN &&
                            size_new <= whp_pkg::FMT_MAX && !cur.fmt_seen)
                        begin
                            nxt.phase = whp_pkg::PH_FMT;
                        end
                        else if (cur.id_shift == whp_pkg::CC_DATA)
                        begin
                            if (cur.fmt_seen)
                            begin
                                nxt.phase = whp_pkg::PH_DATA;
                            end
                            else
                            begin
                                nxt.phase      = whp_pkg::PH_ERR;
                                nxt.error_code = whp_pkg::ST_NO_FMT;
                            end
                        end
                        else if (size_new == 32'd0)
                        begin
                            nxt.phase = whp_pkg::PH_CHUNK;
                        end
                        else
                        begin
                            nxt.phase = whp_pkg::PH_SKIP;
                        end
                    end
                end
                whp_pkg::PH_FMT:
                begin
                    case (cur.byte_count)
                        17'd2:   nxt.chan[7:0]    = in_byte;
                        17'd3:   nxt.chan[15:8]   = in_byte;
                        17'd4:   nxt.rate[7:0]    = in_byte;
                        17'd5:   nxt.rate[15:8]   = in_byte;
                        17'd6:   nxt.rate[23:16]  = in_byte;
                        17'd7:   nxt.rate[31:24]  = in_byte;
                        17'd14:  nxt.depth[7:0]   = in_byte;
                        17'd15:  nxt.depth[15:8]  = in_byte;
                        default:
                        begin
                        end
                    endcase
                    if ({15'd0, cnt_inc} >= cur.size_shift)
                    begin
                        nxt.fmt_seen   = 1'b1;
                        nxt.phase      = whp_pkg::PH_CHUNK;
                        nxt.byte_count = '0;
                    end
                    else
                    begin
                        nxt.byte_count = cnt_inc;
                    end
                end
                whp_pkg::PH_SKIP:
                begin
                    nxt.size_shift = size_dec;
                    if (size_dec == 32'd0)
                    begin
                        nxt.phase      = whp_pkg::PH_CHUNK;
                        nxt.byte_count = '0;
                    end
                end
                whp_pkg::PH_DATA:
                begin
                    res.payload       = in_byte;
                    res.payload_valid = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (nxt.phase == whp_pkg::PH_ERR)
            res.status = nxt.error_code;
        else if (nxt.phase == whp_pkg::PH_DATA)
            res.status = whp_pkg::ST_IN_DATA;
        else
            res.status = whp_pkg::ST_PARSING;
    end

endmodule

[rtl/wav_header_parser.sv]
// ---------------------------------------------------------------------------
// WAV header parser
// Parses a RIFF/RF64 WAVE header byte by byte and passes the data bytes on.
// ---------------------------------------------------------------------------
// An accepted item goes into the input register, then through the parser step
// into the result register.
// Throughput: one item per cycle while the output is not stalled; the loop of
// the parser state register closes through a single step of header logic.
// Reset (rst_n low, asynchronous) returns the parser to the RIFF header phase
// with all fields cleared and empties both pipeline registers.
`include "assert_macros.svh"

module wav_header_parser
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        end_mark,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] channel_count,
    output logic [31:0] rate_hz,
    output logic [15:0] depth_bits,
    output logic [7:0]  payload,
    output logic        payload_valid
);

    // Input register. It holds one item until the step logic can retire it
    // into the result register.
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       end_mark_reg;

    // Parser state, updated once per retired item.
    whp_pkg::parse_state_t state_reg;
    whp_pkg::parse_state_t state_next;
    whp_pkg::step_result_t step_res;

    // Result register.
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [2:0]  status_reg;
    logic [15:0] chan_reg;
    logic [31:0] rate_reg;
    logic [15:0] depth_reg;
    logic [7:0]  payload_reg;
    logic        payload_valid_reg;

    logic out_free;
    logic retire;

    // The result register can take a new item when it is empty or its item
    // is being taken downstream in this same cycle.
    assign out_free = !out_valid_reg || !out_stall;
    assign retire   = in_valid_reg && out_free;

    // The input register is refilled whenever its item leaves or it is empty,
    // so a new item is accepted every cycle while the output keeps moving.
    assign in_stall       = in_valid_reg && !out_free;
    assign in_valid_next  = in_stall ? in_valid_reg : in_valid;
    assign out_valid_next = retire ? 1'b1 : (out_valid_reg && out_stall);

    whp_step u_step
    (
        .cur      (state_reg),
        .in_byte  (in_byte_reg),
        .end_mark (end_mark_reg),
        .nxt      (state_next),
        .res      (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: whp_pkg::PH_RIFF, default: '0};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (retire)
                state_reg <= state_next;
        end
    end

    // Payload registers need no reset; their valid bits guard them.
    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            in_byte_reg  <= in_byte;
            end_mark_reg <= end_mark;
        end
        if (retire)
        begin
            status_reg        <= step_res.status;
            chan_reg          <= state_next.chan;
            rate_reg          <= state_next.rate;
            depth_reg         <= state_next.depth;
            payload_reg       <= step_res.payload;
            payload_valid_reg <= step_res.payload_valid;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign channel_count = chan_reg;
    assign rate_hz       = rate_reg;
    assign depth_bits    = depth_reg;
    assign payload       = payload_reg;
    assign payload_valid = payload_valid_reg;

    // A passed-through byte is only ever reported in the data phase.
    `ASSERT_IMPL(a_payload_in_data, out_valid_reg && payload_valid_reg, status_reg == whp_pkg::ST_IN_DATA, "payload outside data phase")
    // Errors are sticky until reset.
    `ASSERT_NEXT(a_error_sticky, state_reg.phase == whp_pkg::PH_ERR, state_reg.phase == whp_pkg::PH_ERR, "parser left the error phase")
    // The data phase is only reachable after a fmt chunk was read.
    `ASSERT_IMPL(a_data_needs_fmt, state_reg.phase == whp_pkg::PH_DATA, state_reg.fmt_seen, "data phase without fmt chunk")
    // The parser state moves only when an item is retired.
    `ASSERT_NEXT(a_state_holds, !retire, $stable(state_reg), "parser state changed without an item")

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// WAV header parser testbench
// Builds one byte stream per run (RIFF or RF64 header, a mix of chunks, then
// the data chunk or a stream that breaks off in a chosen place), drives it
// with bursty valid and random output stall, and checks every result item
// against a cycle-free model of the parser held in a scoreboard.
// ---------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 2_000_000;

    // One result item as the block presents it on its output ports.
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] chan;
        logic [31:0] rate;
        logic [15:0] depth;
        logic [7:0]  payload;
        logic        payload_valid;
    } parser_out_t;

    // One input item: a stream byte, or the end marker when fin is set.
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } stream_item_t;

    // How the stream of this run ends. Every ending other than the data chunk
    // leaves the parser in a sticky error state.
    typedef enum logic [2:0] {
        END_IN_DATA,
        END_NOT_WAV,
        END_IN_CHUNK,
        END_IN_FMT,
        END_IN_SKIP,
        END_NO_FMT
    } stream_ending_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_pattern_t;

    // -----------------------------------------------------------------------
    // Scoreboard: tracks the parser state item by item and keeps the results
    // that are still owed by the block, oldest first.
    // -----------------------------------------------------------------------
    class wav_step_scoreboard;
        logic [2:0]  phase;
        logic [31:0] pos;
        logic [31:0] id_bits;
        logic [31:0] size_bits;
        logic [15:0] chan;
        logic [31:0] rate;
        logic [15:0] depth;
        logic        fmt_taken;
        logic [2:0]  err_status;
        parser_out_t expected_steps[$];
        int unsigned items_noted;
        int unsigned payload_bytes;
        int unsigned mismatches;

        function new();
            phase = whp_pkg::PH_RIFF;
            pos = '0;
            id_bits = '0;
            size_bits = '0;
            chan = '0;
            rate = '0;
            depth = '0;
            fmt_taken = 1'b0;
            err_status = whp_pkg::ST_PARSING;
            items_noted = 0;
            payload_bytes = 0;
            mismatches = 0;
        endfunction

        function void enter_error(logic [2:0] code);
            phase = whp_pkg::PH_ERR;
            err_status = code;
        endfunction

        function int waiting();
            return expected_steps.size();
        endfunction

        // Advances the parser by one accepted item and queues its result.
        function void note_item(logic [7:0] b, logic fin);
            parser_out_t r;
            r = '0;
            items_noted++;
            if (fin)
            begin
                case (phase)
                    whp_pkg::PH_RIFF:  enter_error(whp_pkg::ST_NOT_WAV);
                    whp_pkg::PH_CHUNK: enter_error(whp_pkg::ST_NO_DATA);
                    whp_pkg::PH_FMT:   enter_error(whp_pkg::ST_FMT_SHORT);
                    whp_pkg::PH_SKIP:  enter_error(whp_pkg::ST_SKIP_SHORT);
                    default:  ;
                endcase
            end
            else
            begin
                case (phase)
                    whp_pkg::PH_RIFF:
                    begin
                        id_bits = {id_bits[23:0], b};
                        if (pos == 3 && id_bits != whp_pkg::CC_RIFF &&
                            id_bits != whp_pkg::CC_RF64)
                            enter_error(whp_pkg::ST_NOT_WAV);
                        else if (pos == 11)
                        begin
                            if (id_bits != whp_pkg::CC_WAVE)
                                enter_error(whp_pkg::ST_NOT_WAV);
                            else
                            begin
                                phase = whp_pkg::PH_CHUNK;
                                pos = '0;
                            end
                        end
                        else
                            pos++;
                    end
                    whp_pkg::PH_CHUNK:
                    begin
                        if (pos < 4)
                            id_bits = {id_bits[23:0], b};
                        else
                            size_bits = {b, size_bits[31:8]};
                        if (pos != 7)
                            pos++;
                        else
                        begin
                            pos = '0;
                            if (id_bits == whp_pkg::CC_FMT && size_bits >= whp_pkg::FMT_MIN &&
                                size_bits <= whp_pkg::FMT_MAX && !fmt_taken)
                                phase = whp_pkg::PH_FMT;
                            else if (id_bits == whp_pkg::CC_DATA)
                            begin
                                if (fmt_taken)
                                    phase = whp_pkg::PH_DATA;
                                else
                                    enter_error(whp_pkg::ST_NO_FMT);
                            end
                            else if (size_bits == 0)
                                phase = whp_pkg::PH_CHUNK;
                            else
                                phase = whp_pkg::PH_SKIP;
                        end
                    end
                    whp_pkg::PH_FMT:
                    begin
                        case (pos)
                            2:  chan[7:0] = b;
                            3:  chan[15:8] = b;
                            4:  rate[7:0] = b;
                            5:  rate[15:8] = b;
                            6:  rate[23:16] = b;
                            7:  rate[31:24] = b;
                            14: depth[7:0] = b;
                            15: depth[15:8] = b;
                            default: ;
                        endcase
                        pos++;
                        if (pos >= size_bits)
                        begin
                            fmt_taken = 1'b1;
                            phase = whp_pkg::PH_CHUNK;
                            pos = '0;
                        end
                    end
                    whp_pkg::PH_SKIP:
                    begin
                        size_bits--;
                        if (size_bits == 0)
                        begin
                            phase = whp_pkg::PH_CHUNK;
                            pos = '0;
                        end
                    end
                    whp_pkg::PH_DATA:
                    begin
                        r.payload = b;
                        r.payload_valid = 1'b1;
                        payload_bytes++;
                    end
                    default: ;
                endcase
            end
            if (phase == whp_pkg::PH_ERR)
                r.status = err_status;
            else if (phase == whp_pkg::PH_DATA)
                r.status = whp_pkg::ST_IN_DATA;
            else
                r.status = whp_pkg::ST_PARSING;
            r.chan = chan;
            r.rate = rate;
            r.depth = depth;
            expected_steps.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        // Compares one accepted result item with the oldest one still owed.
        function void check_result(parser_out_t got);
            parser_out_t want;
            if (expected_steps.size() == 0)
            begin
                mismatches++;
                $display("%0t: result item with nothing owed, expected none actual %0h",
                         $time, got);
                return;
            end
            want = expected_steps.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("channel_count", 32'(want.chan), 32'(got.chan));
            compare_field("rate_hz", want.rate, got.rate);
            compare_field("depth_bits", 32'(want.depth), 32'(got.depth));
            compare_field("payload", 32'(want.payload), 32'(got.payload));
            compare_field("payload_valid", 32'(want.payload_valid),
                          32'(got.payload_valid));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        end_mark;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] depth_bits;
    logic [7:0]  payload;
    logic        payload_valid;

    wav_step_scoreboard sb;
    stream_item_t       stream_q[$];
    stream_ending_t     ending;
    int unsigned        fmt_size;
    logic               fmt_done;
    int unsigned        cycle_count = 0;
    stall_pattern_t     stall_mode = STALL_NONE;
    int                 stall_left = 0;

    wav_header_parser u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .end_mark      (end_mark),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .channel_count (channel_count),
        .rate_hz       (rate_hz),
        .depth_bits    (depth_bits),
        .payload       (payload),
        .payload_valid (payload_valid)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // -----------------------------------------------------------------------
    // Stream building. The whole stream is laid out before reset is released;
    // the scoreboard, not the builder, decides what each byte means.
    // -----------------------------------------------------------------------
    task automatic add_item(input logic [7:0] b, input logic fin);
        stream_item_t it;
        it.data = b;
        it.fin = fin;
        stream_q.push_back(it);
    endtask

    // Four-character codes go out first character first.
    task automatic add_word_be(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            add_item(w[8*i +: 8], 1'b0);
    endtask

    // Sizes are little-endian.
    task automatic add_word_le(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            add_item(w[8*i +: 8], 1'b0);
    endtask

    task automatic add_chunk_header(input logic [31:0] id, input logic [31:0] body_len);
        add_word_be(id);
        add_word_le(body_len);
    endtask

    // Random bytes; with end_one_in above zero, roughly one item in that many
    // is an end marker instead (its byte is random and must be ignored).
    task automatic add_random_bytes(input int n, input int end_one_in);
        logic fin;
        for (int i = 0; i < n; i++)
        begin
            fin = (end_one_in > 0) && ($urandom_range(1, end_one_in) == 1);
            add_item(8'($urandom_range(0, 255)), fin);
        end
    endtask

    // A chunk id that is neither of the two ids the parser acts on.
    function automatic logic [31:0] random_chunk_id();
        logic [31:0] id;
        id = $urandom;
        while (id == whp_pkg::CC_FMT || id == whp_pkg::CC_DATA)
            id = $urandom;
        return id;
    endfunction

    // The first fmt chunk with an accepted size: sometimes the minimum, otherwise
    // 17 to 48 bytes.
    task automatic add_fmt_chunk();
        int r;
        r = $urandom_range(0, 15);
        if (r < 6)
            fmt_size = whp_pkg::FMT_MIN;
        else
            fmt_size = $urandom_range(17, 48);
        add_chunk_header(whp_pkg::CC_FMT, fmt_size);
        add_random_bytes(fmt_size, 0);
        fmt_done = 1'b1;
    endtask

    // -----------------------------------------------------------------------
    // Sender. Valid is lowered only at the start of an idle stretch and raised
    // again at a later edge, so each step sees one assignment at most.
    // -----------------------------------------------------------------------
    task automatic pause_sender(input int cycles, input bit until_drained);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
        while (until_drained && sb.waiting() != 0)
            @(posedge clk);
    endtask

    // Holds the item until an edge at which the block is not stalling.
    task automatic send_item(input stream_item_t it);
        in_valid <= 1'b1;
        in_byte <= it.data;
        end_mark <= it.fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(it.data, it.fin);
    endtask

    // -----------------------------------------------------------------------
    // Receiver and result check. After each stretch of random length the stall
    // pattern is picked anew among no stall, light and heavy random stall, and toggling.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({status, channel_count, rate_hz, depth_bits,
                             payload, payload_valid});
        if (stall_left == 0)
        begin
            stall_mode = stall_pattern_t'($urandom_range(0, 3));
            stall_left = $urandom_range(8, 80);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ~out_stall;
        endcase
    end

    // A hung handshake ends the run here.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Run stopped after %0d cycles with %0d result items still owed",
                 cycle_count, sb.waiting());
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int          pick;
        int          k;
        int          burst_left;
        int          drain_at;
        int          body_target;
        logic [31:0] body_len;
        logic [31:0] id;
        logic        allow_fmt;

        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = '0;
        end_mark = 1'b0;
        out_stall = 1'b0;
        fmt_size = 0;
        fmt_done = 1'b0;

        // Since errors hold until reset and reset comes only once, each run
        // ends its stream in one way; the seed picks which. Most runs reach
        // the data chunk.
        case ($urandom_range(0, 11))
            6:       ending = END_NOT_WAV;
            7:       ending = END_IN_CHUNK;
            8:       ending = END_IN_FMT;
            9:       ending = END_IN_SKIP;
            10:      ending = END_NO_FMT;
            default: ending = END_IN_DATA;
        endcase

        if (ending == END_NOT_WAV)
        begin
            // A broken file header: a wrong first code, a wrong WAVE code, or
            // the end marker somewhere inside the twelve header bytes.
            case ($urandom_range(0, 2))
                0:
                begin
                    id = whp_pkg::CC_RIFF ^
                         (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
                    add_word_be(id);
                    add_random_bytes(8, 0);
                end
                1:
                begin
                    add_word_be($urandom_range(0, 1) ? whp_pkg::CC_RF64 : whp_pkg::CC_RIFF);
                    add_word_le($urandom);
                    add_word_be(whp_pkg::CC_WAVE ^ (32'($urandom_range(1, 255)) <<
                                                    (8 * $urandom_range(0, 3))));
                end
                default:
                begin
                    k = $urandom_range(0, 11);
                    add_word_be(whp_pkg::CC_RIFF);
                    add_word_le($urandom);
                    add_word_be(whp_pkg::CC_WAVE);
                    while (stream_q.size() > k)
                        void'(stream_q.pop_back());
                    add_random_bytes(1, 1);
                end
            endcase
        end
        else
        begin
            // Directed opening: either first code, a size field with bytes at
            // both extremes, and an empty fmt chunk, which is too short to be
            // taken and so is passed over as an empty chunk.
            add_word_be($urandom_range(0, 1) ? whp_pkg::CC_RF64 : whp_pkg::CC_RIFF);
            add_word_le(32'hFF00_FF00);
            add_word_be(whp_pkg::CC_WAVE);
            add_chunk_header(whp_pkg::CC_FMT, 32'd0);

            // Random chunk list. The endings that test a short or missing fmt
            // chunk must not see an accepted one first.
            allow_fmt = (ending == END_IN_DATA || ending == END_IN_CHUNK ||
                         ending == END_IN_SKIP);
            body_target = (ending == END_IN_DATA) ? 300 : 560;
            while (stream_q.size() < body_target)
            begin
                pick = $urandom_range(0, 11);
                if (pick == 11 && allow_fmt && !fmt_done)
                    add_fmt_chunk();
                else if (pick == 10)
                begin
                    // An fmt chunk the parser must skip: too short, or late.
                    body_len = fmt_done ? $urandom_range(16, 24) : $urandom_range(0, 15);
                    add_chunk_header(whp_pkg::CC_FMT, body_len);
                    add_random_bytes(body_len, 0);
                end
                else if (pick == 9)
                begin
                    // An id one bit away from fmt or data.
                    id = ($urandom_range(0, 1) ? whp_pkg::CC_FMT : whp_pkg::CC_DATA) ^
                         (32'h1 << $urandom_range(0, 31));
                    body_len = $urandom_range(0, 12);
                    add_chunk_header(id, body_len);
                    add_random_bytes(body_len, 0);
                end
                else
                begin
                    body_len = (pick == 0) ? 0 : $urandom_range(1, 24);
                    add_chunk_header(random_chunk_id(), body_len);
                    add_random_bytes(body_len, 0);
                end
            end

            case (ending)
                END_IN_DATA:
                begin
                    if (!fmt_done)
                        add_fmt_chunk();
                    add_chunk_header(whp_pkg::CC_DATA, $urandom);
                    // Payload with scattered end markers, which data ignores.
                    add_random_bytes((stream_q.size() < 550) ? 600 - stream_q.size() : 50, 20);
                end
                END_NO_FMT:
                    add_chunk_header(whp_pkg::CC_DATA, $urandom);
                END_IN_CHUNK:
                begin
                    // Cut anywhere in a chunk header, right at its start too.
                    add_random_bytes($urandom_range(0, 7), 0);
                    add_random_bytes(1, 1);
                end
                END_IN_FMT:
                begin
                    body_len = ($urandom_range(0, 3) == 0) ? whp_pkg::FMT_MAX
                                                           : $urandom_range(16, 40);
                    add_chunk_header(whp_pkg::CC_FMT, body_len);
                    add_random_bytes($urandom_range(0, 15), 0);
                    add_random_bytes(1, 1);
                end
                default:
                begin
                    // A skipped chunk with a full 32-bit size, cut short.
                    k = $urandom_range(0, 20);
                    body_len = $urandom;
                    if (body_len <= k)
                        body_len = k + 1;
                    add_chunk_header(random_chunk_id(), body_len);
                    add_random_bytes(k, 0);
                    add_random_bytes(1, 1);
                end
            endcase
        end

        // After an error the state must hold whatever arrives. A stream that
        // broke off in its file header is filled up to the usual run length.
        if (ending != END_IN_DATA)
            add_random_bytes((stream_q.size() < 560) ? 600 - stream_q.size() : 40, 6);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bursts of random length, mostly short, some long enough to run with
        // no idle at all. Once, somewhere in the middle, the sender waits for
        // every owed result before going on.
        burst_left = 0;
        drain_at = $urandom_range(stream_q.size() / 4, stream_q.size() * 3 / 4);
        foreach (stream_q[i])
        begin
            if (i == drain_at)
                pause_sender(1, 1'b1);
            else if (burst_left <= 0)
            begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                         : $urandom_range(1, 24);
                pause_sender($urandom_range(1, 6), 1'b0);
            end
            send_item(stream_q[i]);
            burst_left--;
        end
        in_valid <= 1'b0;

        // Let the pipeline empty, then keep watching so that any extra result item
        // would show up.
        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d items in a stream ending %s, %0d payload bytes passed on.",
                 sb.items_noted, ending.name(), sb.payload_bytes);
        $display("Accepted fmt chunk size %0d (0 when none), %0d field mismatches.",
                 fmt_size, sb.mismatches);
        if (sb.mismatches == 0 && sb.waiting() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/whp_pkg.sv
rtl/whp_step.sv
rtl/wav_header_parser.sv
test/testbench.sv
